// ===== rtl/fccw_pkg.sv =====
// shared types, constants and codes of the cluster chain table writer
package fccw_pkg;

   localparam int TABLE_WORDS_DEF = 4096;
   localparam int WORD_W          = 16;
   localparam int CLUSTER_W       = 16;
   localparam int BYTES_W         = 31;
   localparam int INDEX_W         = 12;
   localparam int CLW             = CLUSTER_W + 1;

   localparam logic [WORD_W-1:0]    END_MARK          = 16'hffff;
   localparam logic [CLUSTER_W-1:0] CLUSTER_BYTES_RST = 16'd512;

   typedef enum logic {
      OP_CHAIN = 1'b0,
      OP_READ  = 1'b1
   } op_type;

   typedef enum logic {
      CSR_WIDE_ENTRIES  = 1'b0,
      CSR_CLUSTER_BYTES = 1'b1
   } csr_idx_type;

   typedef struct packed {
      op_type               operation;
      logic [CLUSTER_W-1:0] first_cluster;
      logic [BYTES_W-1:0]   file_bytes;
      logic [INDEX_W-1:0]   word_index;
   } req_type;

   typedef struct packed {
      logic [CLUSTER_W-1:0] free_cluster;
      logic [WORD_W-1:0]    read_data;
      logic                 table_overflow;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ_ISSUE,
      ST_READ_WAIT,
      ST_ENTRY,
      ST_MERGE_LO,
      ST_MERGE_HI,
      ST_DONE
   } state_type;

   typedef enum logic [1:0] {
      RES_NONE,
      RES_READ,
      RES_LAST,
      RES_OVF
   } res_sel_type;

   typedef struct packed {
      logic        clear_write;
      logic        load_req;
      logic        rsv_sel;
      logic        rsv_idx;
      logic        read_req;
      logic        write_wide;
      logic        read_lo;
      logic        merge_lo;
      logic        read_hi;
      logic        merge_hi;
      logic        advance;
      res_sel_type res_sel;
      logic        load_rsp;
   } cmd_type;

   typedef struct packed {
      logic clear_last;
      logic fits;
      logic wide;
      logic split;
      logic last_entry;
   } status_type;

endpackage

// ===== rtl/fccw_datapath.sv =====
// table memory, chain counters, entry packing and result registers
module fccw_datapath #(
   parameter int TABLE_WORDS = fccw_pkg::TABLE_WORDS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  fccw_pkg::cmd_type            cmd,
   output fccw_pkg::status_type         status,
   input  fccw_pkg::req_type            req_data,
   output fccw_pkg::rsp_type            rsp_data,
   input  logic                         csr_write,
   input  fccw_pkg::csr_idx_type        csr_index,
   input  logic [fccw_pkg::WORD_W-1:0]  csr_data
);

   localparam int               AW        = $clog2(TABLE_WORDS);
   localparam logic [17:0]      TW18      = 18'(TABLE_WORDS);
   localparam logic [AW-1:0]    LAST_ADDR = AW'(TABLE_WORDS - 1);

   // low word of a packed entry
   function automatic logic [15:0] merge_lo_word(logic [15:0] old, logic [1:0] ph,
                                                logic [11:0] v);
      logic [15:0] res;
      unique case (ph)
         2'd0: res = (old & 16'hf000) | {4'h0, v};
         2'd1: res = (old & 16'h0fff) | {v[3:0], 12'h000};
         2'd2: res = (old & 16'h00ff) | {v[7:0], 8'h00};
         2'd3: res = (old & 16'h000f) | {v, 4'h0};
      endcase
      return res;
   endfunction

   // spill-over word of an entry that straddles two words
   function automatic logic [15:0] merge_hi_word(logic [15:0] old, logic [1:0] ph,
                                                logic [11:0] v);
      logic [15:0] res;
      unique case (ph)
         2'd1:    res = (old & 16'hff00) | {8'h00, v[11:4]};
         2'd2:    res = (old & 16'hfff0) | {12'h000, v[11:8]};
         default: res = old;
      endcase
      return res;
   endfunction

   logic                     wide_ff;
   logic [15:0]              cbytes_ff;
   fccw_pkg::req_type        req_ff;
   logic [fccw_pkg::CLW-1:0] cl_ff, cl_in;
   logic [30:0]              rem_ff, rem_in;
   logic [AW-1:0]            clr_cnt_ff;
   logic [15:0]              rdata_ff;
   fccw_pkg::rsp_type        res_ff, res_in;
   fccw_pkg::rsp_type        rsp_ff;

   logic [15:0]              table_mem [TABLE_WORDS];

   logic [15:0]              cb_eff;
   logic [fccw_pkg::CLW-1:0] entry_cl;
   logic [1:0]               phase;
   logic [17:0]              triple;
   logic [17:0]              lo_word;
   logic [17:0]              hi_word;
   logic [17:0]              last_word;
   logic                     split;
   logic                     fits;
   logic                     last_entry;
   logic [15:0]              link_val;
   logic                     idx_ok;
   logic [16:0]              idx_ext;
   logic                     we, re;
   logic [AW-1:0]            waddr, raddr;
   logic [15:0]              wdata;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         wide_ff   <= 1'b0;
         cbytes_ff <= fccw_pkg::CLUSTER_BYTES_RST;
      end else if (csr_write) begin
         unique case (csr_index)
            fccw_pkg::CSR_WIDE_ENTRIES:  wide_ff   <= csr_data[0];
            fccw_pkg::CSR_CLUSTER_BYTES: cbytes_ff <= csr_data;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff <= '0;
      end else if (cmd.clear_write) begin
         clr_cnt_ff <= clr_cnt_ff + AW'(1);
      end
   end

   assign cb_eff   = (cbytes_ff == 16'd0) ? 16'd1 : cbytes_ff;
   assign entry_cl = cmd.rsv_sel ? fccw_pkg::CLW'(cmd.rsv_idx) : cl_ff;
   assign phase    = entry_cl[1:0];
   assign triple   = {entry_cl, 1'b0} + {1'b0, entry_cl};
   assign lo_word  = 18'(triple[17:2]);
   assign hi_word  = lo_word + 18'd1;
   assign split    = (phase == 2'd1) || (phase == 2'd2);
   assign last_word = split ? hi_word : lo_word;
   assign fits     = !entry_cl[16] &&
                     (wide_ff ? (18'(entry_cl) < TW18) : (last_word < TW18));
   assign last_entry = rem_ff <= 31'(cb_eff);
   assign link_val = (cmd.rsv_sel || last_entry) ? fccw_pkg::END_MARK
                                                 : entry_cl[15:0] + 16'd1;
   assign idx_ext  = 17'(req_ff.word_index);
   assign idx_ok   = idx_ext < 17'(TABLE_WORDS);

   always_comb begin
      cl_in  = cl_ff;
      rem_in = rem_ff;
      if (cmd.load_req) begin
         cl_in  = fccw_pkg::CLW'(req_data.first_cluster);
         rem_in = req_data.file_bytes;
      end else if (cmd.advance) begin
         cl_in  = cl_ff + fccw_pkg::CLW'(1);
         rem_in = rem_ff - 31'(cb_eff);
      end
   end

   always_ff @(posedge clock) begin
      cl_ff  <= cl_in;
      rem_ff <= rem_in;
      if (cmd.load_req) begin
         req_ff <= req_data;
      end
   end

   // memory ports
   always_comb begin
      we    = 1'b0;
      waddr = '0;
      wdata = '0;
      priority if (cmd.clear_write) begin
         we    = 1'b1;
         waddr = clr_cnt_ff;
      end else if (cmd.write_wide) begin
         we    = 1'b1;
         waddr = entry_cl[AW-1:0];
         wdata = link_val;
      end else if (cmd.merge_lo) begin
         we    = 1'b1;
         waddr = lo_word[AW-1:0];
         wdata = merge_lo_word(rdata_ff, phase, link_val[11:0]);
      end else if (cmd.merge_hi) begin
         we    = 1'b1;
         waddr = hi_word[AW-1:0];
         wdata = merge_hi_word(rdata_ff, phase, link_val[11:0]);
      end
   end

   always_comb begin
      re    = 1'b0;
      raddr = '0;
      priority if (cmd.read_req) begin
         re    = 1'b1;
         raddr = idx_ext[AW-1:0];
      end else if (cmd.read_lo) begin
         re    = 1'b1;
         raddr = lo_word[AW-1:0];
      end else if (cmd.read_hi) begin
         re    = 1'b1;
         raddr = hi_word[AW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (we) begin
         table_mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= table_mem[raddr];
      end
   end

   // result staging and output register
   always_comb begin
      res_in = res_ff;
      unique case (cmd.res_sel)
         fccw_pkg::RES_NONE: res_in = res_ff;
         fccw_pkg::RES_READ: begin
            res_in.free_cluster   = '0;
            res_in.read_data      = idx_ok ? rdata_ff : 16'd0;
            res_in.table_overflow = 1'b0;
         end
         fccw_pkg::RES_LAST: begin
            res_in.free_cluster   = cl_ff[15:0] + 16'd1;
            res_in.read_data      = '0;
            res_in.table_overflow = 1'b0;
         end
         fccw_pkg::RES_OVF: begin
            res_in.free_cluster   = cl_ff[15:0];
            res_in.read_data      = '0;
            res_in.table_overflow = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      res_ff <= res_in;
      if (cmd.load_rsp) begin
         rsp_ff <= res_ff;
      end
   end

   assign rsp_data          = rsp_ff;
   assign status.clear_last = clr_cnt_ff == LAST_ADDR;
   assign status.fits       = fits;
   assign status.wide       = wide_ff;
   assign status.split      = split;
   assign status.last_entry = last_entry;

endmodule

// ===== rtl/fccw_ctrl.sv =====
// sequencer for clearing, table reads and chain writes
module fccw_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  fccw_pkg::op_type      req_op,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  fccw_pkg::status_type  status,
   output fccw_pkg::cmd_type     cmd
);

   fccw_pkg::state_type state_ff, state_in;
   logic                rsv_active_ff, rsv_active_in;
   logic                rsv_idx_ff, rsv_idx_in;
   logic                marked_ff, marked_in;
   logic                rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= fccw_pkg::ST_CLEAR;
         rsv_active_ff <= 1'b0;
         rsv_idx_ff    <= 1'b0;
         marked_ff     <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsv_active_ff <= rsv_active_in;
         rsv_idx_ff    <= rsv_idx_in;
         marked_ff     <= marked_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_comb begin
      logic entry_done;
      entry_done    = 1'b0;
      state_in      = state_ff;
      rsv_active_in = rsv_active_ff;
      rsv_idx_in    = rsv_idx_ff;
      marked_in     = marked_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      cmd           = '0;
      cmd.res_sel   = fccw_pkg::RES_NONE;
      cmd.rsv_sel   = rsv_active_ff;
      cmd.rsv_idx   = rsv_idx_ff;
      req_ready     = state_ff == fccw_pkg::ST_IDLE;

      unique case (state_ff)
         fccw_pkg::ST_CLEAR: begin
            cmd.clear_write = 1'b1;
            if (status.clear_last) begin
               state_in = fccw_pkg::ST_IDLE;
            end
         end
         fccw_pkg::ST_IDLE: begin
            if (req_valid) begin
               cmd.load_req = 1'b1;
               if (req_op == fccw_pkg::OP_READ) begin
                  state_in = fccw_pkg::ST_READ_ISSUE;
               end else begin
                  state_in = fccw_pkg::ST_ENTRY;
                  if (!marked_ff) begin
                     rsv_active_in = 1'b1;
                     rsv_idx_in    = 1'b0;
                  end
               end
            end
         end
         fccw_pkg::ST_READ_ISSUE: begin
            cmd.read_req = 1'b1;
            state_in     = fccw_pkg::ST_READ_WAIT;
         end
         fccw_pkg::ST_READ_WAIT: begin
            cmd.res_sel = fccw_pkg::RES_READ;
            state_in    = fccw_pkg::ST_DONE;
         end
         fccw_pkg::ST_ENTRY: begin
            if (!status.fits) begin
               cmd.res_sel = fccw_pkg::RES_OVF;
               state_in    = fccw_pkg::ST_DONE;
            end else if (status.wide) begin
               cmd.write_wide = 1'b1;
               entry_done     = 1'b1;
            end else begin
               cmd.read_lo = 1'b1;
               state_in    = fccw_pkg::ST_MERGE_LO;
            end
         end
         fccw_pkg::ST_MERGE_LO: begin
            cmd.merge_lo = 1'b1;
            if (status.split) begin
               cmd.read_hi = 1'b1;
               state_in    = fccw_pkg::ST_MERGE_HI;
            end else begin
               entry_done = 1'b1;
            end
         end
         fccw_pkg::ST_MERGE_HI: begin
            cmd.merge_hi = 1'b1;
            entry_done   = 1'b1;
         end
         fccw_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_rsp = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = fccw_pkg::ST_IDLE;
            end
         end
      endcase

      // entry written: step to the next one or finish the chain
      if (entry_done) begin
         if (rsv_active_ff) begin
            state_in = fccw_pkg::ST_ENTRY;
            if (!rsv_idx_ff) begin
               rsv_idx_in = 1'b1;
            end else begin
               rsv_active_in = 1'b0;
               marked_in     = 1'b1;
            end
         end else if (status.last_entry) begin
            cmd.res_sel = fccw_pkg::RES_LAST;
            state_in    = fccw_pkg::ST_DONE;
         end else begin
            cmd.advance = 1'b1;
            state_in    = fccw_pkg::ST_ENTRY;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== rtl/fat_cluster_chain_writer_core.sv =====
// top level of the fat12/fat16 cluster chain table writer
//
// usage
// - req channel: one item is either a chain write (first cluster, file size)
//   or a read of one table word; req_ready is high only while the block idles
// - rsp channel: one item per request; free_cluster after a chain, read_data
//   for a read, table_overflow when the chain hit the table end
// - csr channel: index 0 selects 16-bit entries, index 1 sets cluster bytes;
//   always ready; write only while no request is in flight (not enforced)
// - a read passes the issue, wait and done states before rsp_valid rises
// - a chain raises rsp_valid after its last entry; each entry is one write
//   (16-bit entries) or one table read-modify-write per word touched, two
//   words when the entry straddles them (packed 12-bit entries); the entry
//   that does not fit at the table end ends the chain; the first chain after
//   reset adds the two reserved entries
// - one item at a time; the next item is taken once the block is idle again,
//   which it reaches as rsp_valid rises
// - entries are paced by the single read and single write port of the table
// - reset: a clearing pass zeroes one table word per cycle, all TABLE_WORDS
//   words, with req_ready low; csr writes are taken during it
// - a stalled rsp holds in the output register; the next item is still
//   taken and worked on, and waits at the end until the register frees
module fat_cluster_chain_writer_core #(
   parameter int TABLE_WORDS = fccw_pkg::TABLE_WORDS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   // request channel
   input  logic                         req_valid,
   output logic                         req_ready,
   input  fccw_pkg::req_type            req_data,
   // response channel
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output fccw_pkg::rsp_type            rsp_data,
   // configuration channel
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  fccw_pkg::csr_idx_type        csr_index,
   input  logic [fccw_pkg::WORD_W-1:0]  csr_data
);

   fccw_pkg::cmd_type    cmd;
   fccw_pkg::status_type status;

   // registers are plain flops, a write never has to wait
   assign csr_ready = 1'b1;

   fccw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_op    (req_data.operation),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   fccw_datapath #(
      .TABLE_WORDS (TABLE_WORDS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_data  (req_data),
      .rsp_data  (rsp_data),
      .csr_write (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

endmodule

// ===== rtl/fccw_checker.sv =====
// port-level checks of the cluster chain table writer, bound to the top level
module fccw_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_ready,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input fccw_pkg::rsp_type            rsp_data
);

   // response held while stalled
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("rsp item changed while stalled");

   // clearing pass follows reset
   a_clear_busy: assert property (@(posedge clock)
      reset |=> !req_ready)
      else $error("request taken during clearing pass");

   // one item in flight at a time
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second item taken while busy");

   a_overflow_no_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.table_overflow |-> rsp_data.read_data == 16'd0)
      else $error("overflow reported on a read item");

   a_read_no_cluster: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.read_data != 16'd0 |-> rsp_data.free_cluster == 16'd0)
      else $error("read item carries a cluster number");

endmodule

bind fat_cluster_chain_writer_core fccw_checker u_fccw_checker (.*);
